// ===== rtl/psl_pkg.sv =====
// Types, token codes and keyword tables of the Pascal subset lexer.
package psl_pkg;

  localparam int NUM_KW = 18;
  localparam int TOK_W  = 6;

  localparam logic [TOK_W-1:0] TOK_ASSIGN = 6'd8;
  localparam logic [TOK_W-1:0] TOK_PLUS   = 6'd15;
  localparam logic [TOK_W-1:0] TOK_MINUS  = 6'd16;
  localparam logic [TOK_W-1:0] TOK_STAR   = 6'd17;
  localparam logic [TOK_W-1:0] TOK_EQ     = 6'd19;
  localparam logic [TOK_W-1:0] TOK_NE     = 6'd20;
  localparam logic [TOK_W-1:0] TOK_LT     = 6'd21;
  localparam logic [TOK_W-1:0] TOK_LE     = 6'd22;
  localparam logic [TOK_W-1:0] TOK_GT     = 6'd23;
  localparam logic [TOK_W-1:0] TOK_GE     = 6'd24;
  localparam logic [TOK_W-1:0] TOK_LPAREN = 6'd28;
  localparam logic [TOK_W-1:0] TOK_RPAREN = 6'd29;
  localparam logic [TOK_W-1:0] TOK_LBRACK = 6'd30;
  localparam logic [TOK_W-1:0] TOK_RBRACK = 6'd31;
  localparam logic [TOK_W-1:0] TOK_COMMA  = 6'd32;
  localparam logic [TOK_W-1:0] TOK_DOT    = 6'd33;
  localparam logic [TOK_W-1:0] TOK_SEMI   = 6'd34;
  localparam logic [TOK_W-1:0] TOK_COLON  = 6'd35;
  localparam logic [TOK_W-1:0] TOK_NUMBER = 6'd36;
  localparam logic [TOK_W-1:0] TOK_IDENT  = 6'd37;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_COLON,
    PEND_LT,
    PEND_GT
  } psl_pend_t;

  typedef struct packed {
    logic              in_word;
    logic              starts_digit;
    logic [NUM_KW-1:0] cand;
    logic [3:0]        pos;
    psl_pend_t         pend;
  } psl_state_t;

  localparam psl_state_t RESET_STATE = '{
    in_word:      1'b0,
    starts_digit: 1'b0,
    cand:         {NUM_KW{1'b1}},
    pos:          4'd0,
    pend:         PEND_NONE
  };

  typedef struct packed {
    logic [TOK_W-1:0] token_class;
    logic             last;
  } psl_tok_t;

  typedef struct packed {
    logic [1:0] n;
    psl_tok_t   t0;
    psl_tok_t   t1;
  } psl_step_t;

  function automatic logic [3:0] kw_len(input logic [4:0] k);
    case (k)
      5'd0:    kw_len = 4'd7;
      5'd1:    kw_len = 4'd5;
      5'd2:    kw_len = 4'd4;
      5'd3:    kw_len = 4'd3;
      5'd4:    kw_len = 4'd9;
      5'd5:    kw_len = 4'd8;
      5'd6:    kw_len = 4'd5;
      5'd7:    kw_len = 4'd3;
      5'd8:    kw_len = 4'd2;
      5'd9:    kw_len = 4'd4;
      5'd10:   kw_len = 4'd4;
      5'd11:   kw_len = 4'd5;
      5'd12:   kw_len = 4'd2;
      5'd13:   kw_len = 4'd4;
      5'd14:   kw_len = 4'd3;
      5'd15:   kw_len = 4'd3;
      5'd16:   kw_len = 4'd2;
      5'd17:   kw_len = 4'd3;
      default: kw_len = 4'd0;
    endcase
  endfunction

  function automatic logic [TOK_W-1:0] kw_code(input logic [4:0] k);
    case (k)
      5'd0:    kw_code = 6'd0;
      5'd1:    kw_code = 6'd1;
      5'd2:    kw_code = 6'd2;
      5'd3:    kw_code = 6'd3;
      5'd4:    kw_code = 6'd4;
      5'd5:    kw_code = 6'd5;
      5'd6:    kw_code = 6'd6;
      5'd7:    kw_code = 6'd7;
      5'd8:    kw_code = 6'd9;
      5'd9:    kw_code = 6'd10;
      5'd10:   kw_code = 6'd11;
      5'd11:   kw_code = 6'd12;
      5'd12:   kw_code = 6'd13;
      5'd13:   kw_code = 6'd14;
      5'd14:   kw_code = 6'd18;
      5'd15:   kw_code = 6'd25;
      5'd16:   kw_code = 6'd26;
      5'd17:   kw_code = 6'd27;
      default: kw_code = TOK_IDENT;
    endcase
  endfunction

  // Character at position pos of keyword k, left aligned in 72 bits.
  function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [3:0] pos);
    logic [71:0] w;
    logic [71:0] sh;
    case (k)
      5'd0:    w = {"program", 16'h0};
      5'd1:    w = {"label", 32'h0};
      5'd2:    w = {"type", 40'h0};
      5'd3:    w = {"var", 48'h0};
      5'd4:    w = "procedure";
      5'd5:    w = {"function", 8'h0};
      5'd6:    w = {"begin", 32'h0};
      5'd7:    w = {"end", 48'h0};
      5'd8:    w = {"if", 56'h0};
      5'd9:    w = {"then", 40'h0};
      5'd10:   w = {"else", 40'h0};
      5'd11:   w = {"while", 32'h0};
      5'd12:   w = {"do", 56'h0};
      5'd13:   w = {"goto", 40'h0};
      5'd14:   w = {"div", 48'h0};
      5'd15:   w = {"and", 48'h0};
      5'd16:   w = {"or", 56'h0};
      5'd17:   w = {"not", 48'h0};
      default: w = '0;
    endcase
    sh = w << {pos, 3'b000};
    kw_char = sh[71:64];
  endfunction

  function automatic logic [TOK_W-1:0] symbol_code(input logic [7:0] c);
    case (c)
      "+":     symbol_code = TOK_PLUS;
      "-":     symbol_code = TOK_MINUS;
      "*":     symbol_code = TOK_STAR;
      "=":     symbol_code = TOK_EQ;
      "(":     symbol_code = TOK_LPAREN;
      ")":     symbol_code = TOK_RPAREN;
      "[":     symbol_code = TOK_LBRACK;
      "]":     symbol_code = TOK_RBRACK;
      ",":     symbol_code = TOK_COMMA;
      ".":     symbol_code = TOK_DOT;
      ";":     symbol_code = TOK_SEMI;
      default: symbol_code = TOK_IDENT;
    endcase
  endfunction

  function automatic logic [TOK_W-1:0] pend_code(input psl_pend_t p);
    case (p)
      PEND_COLON: pend_code = TOK_COLON;
      PEND_LT:    pend_code = TOK_LT;
      PEND_GT:    pend_code = TOK_GT;
      default:    pend_code = TOK_IDENT;
    endcase
  endfunction

endpackage

// ===== rtl/psl_if.sv =====
// Character and token channel interfaces of the Pascal subset lexer.
interface psl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_text;
  modport source(output valid, ch, end_of_text, input ready);
  modport sink(input valid, ch, end_of_text, output ready);
endinterface

interface psl_token_if;
  logic                       valid;
  logic                       ready;
  logic [psl_pkg::TOK_W-1:0] token_class;
  logic                       last;
  modport source(output valid, token_class, last, input ready);
  modport sink(input valid, token_class, last, output ready);
endinterface

// ===== rtl/psl_lexstep.sv =====
// Per-character lexer step: next state and up to two tokens.
module psl_lexstep (
  input  psl_pkg::psl_state_t state,
  input  logic [7:0]          ch,
  input  logic                eot,
  output psl_pkg::psl_state_t state_next,
  output psl_pkg::psl_step_t  step
);
  import psl_pkg::*;

  logic              digit;
  logic              alnum;
  logic              blank;
  logic [TOK_W-1:0]  word_code;
  logic [TOK_W-1:0]  pair_code;
  logic              pair_hit;
  logic              base_in;
  logic [NUM_KW-1:0] base_cand;
  logic [3:0]        base_pos;
  logic [NUM_KW-1:0] add_cand;
  logic              emit_a;
  logic              emit_b;
  logic [TOK_W-1:0]  code_a;
  logic [TOK_W-1:0]  code_b;

  assign digit = (ch >= "0") && (ch <= "9");
  assign alnum = digit || ((ch >= "A") && (ch <= "Z")) || ((ch >= "a") && (ch <= "z"));
  assign blank = (ch == " ") || ((ch >= 8'd9) && (ch <= 8'd13)) || (ch == 8'd0);

  // First keyword still matching whose length equals the word length
  always_comb begin
    word_code = state.starts_digit ? TOK_NUMBER : TOK_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (state.cand[k] && (kw_len(5'(k)) == state.pos)) begin
        word_code = kw_code(5'(k));
      end
    end
  end

  always_comb begin
    base_in   = state.in_word;
    base_cand = state.in_word ? state.cand : {NUM_KW{1'b1}};
    base_pos  = state.in_word ? state.pos : 4'd0;
    for (int k = 0; k < NUM_KW; k++) begin
      add_cand[k] = base_cand[k] && (base_pos < kw_len(5'(k))) &&
                    (kw_char(5'(k), base_pos) == ch);
    end
  end

  always_comb begin
    pair_hit  = 1'b1;
    pair_code = TOK_ASSIGN;
    case (state.pend)
      PEND_COLON: pair_hit = (ch == "=");
      PEND_LT: begin
        pair_hit  = (ch == "=") || (ch == ">");
        pair_code = (ch == "=") ? TOK_LE : TOK_NE;
      end
      PEND_GT: begin
        pair_hit  = (ch == "=");
        pair_code = TOK_GE;
      end
      default: pair_hit = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    emit_a     = 1'b0;
    emit_b     = 1'b0;
    code_a     = (state.pend != PEND_NONE) ? pend_code(state.pend) : word_code;
    code_b     = symbol_code(ch);
    if (eot) begin
      emit_a     = state.in_word || (state.pend != PEND_NONE);
      state_next = RESET_STATE;
    end else if (pair_hit) begin
      emit_a          = 1'b1;
      code_a          = pair_code;
      state_next.pend = PEND_NONE;
    end else begin
      state_next.pend = PEND_NONE;
      if (alnum) begin
        emit_a                  = state.pend != PEND_NONE;
        state_next.in_word      = 1'b1;
        state_next.starts_digit = base_in ? state.starts_digit : digit;
        state_next.cand         = add_cand;
        state_next.pos          = (base_pos == 4'd15) ? base_pos : base_pos + 4'd1;
      end else begin
        emit_a                  = (state.pend != PEND_NONE) || state.in_word;
        state_next.in_word      = 1'b0;
        state_next.starts_digit = 1'b0;
        state_next.cand         = {NUM_KW{1'b1}};
        state_next.pos          = 4'd0;
        if (!blank) begin
          case (ch)
            ":":     state_next.pend = PEND_COLON;
            "<":     state_next.pend = PEND_LT;
            ">":     state_next.pend = PEND_GT;
            default: emit_b = 1'b1;
          endcase
        end
      end
    end
  end

  always_comb begin
    step = '0;
    if (emit_a && emit_b) begin
      step.n  = 2'd2;
      step.t0 = '{token_class: code_a, last: 1'b0};
      step.t1 = '{token_class: code_b, last: 1'b1};
    end else if (emit_a) begin
      step.n  = 2'd1;
      step.t0 = '{token_class: code_a, last: 1'b1};
    end else if (emit_b) begin
      step.n  = 2'd1;
      step.t0 = '{token_class: code_b, last: 1'b1};
    end
  end

endmodule

// ===== rtl/psl_token_fifo.sv =====
// Four-entry token queue taking up to two tokens per cycle.
module psl_token_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  psl_pkg::psl_step_t  step,
  output logic                room,
  psl_token_if.source         tokens
);
  import psl_pkg::*;

  psl_tok_t   mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [1:0] push_n;
  logic       pop;

  assign push_n = push ? step.n : 2'd0;
  assign pop    = tokens.valid && tokens.ready;
  assign room   = count <= 3'd2;

  assign tokens.valid       = count != 3'd0;
  assign tokens.token_class = mem[rd_ptr].token_class;
  assign tokens.last        = mem[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (push && (step.n != 2'd0)) begin
      mem[wr_ptr] <= step.t0;
    end
    if (push && (step.n == 2'd2)) begin
      mem[wr_ptr + 2'd1] <= step.t1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push_n} - {2'b00, pop};
    end
  end

endmodule

// ===== rtl/pascal_subset_lexer.sv =====
// Pascal subset lexer top level: input register, lexer step, token queue.
//
// chars carries one character per request (ch, end_of_text); tokens carries
// token requests (token_class, last). A character that closes a word, or one
// that follows a waiting ':', '<' or '>', may yield two tokens; the final token
// of each character has last set. Blanks, letters and digits inside a word and
// the first half of a possible pair yield nothing.
// A character accepted on chars is held in the input register; its tokens are
// written to the queue when that register advances, and shown on tokens from then on.
// Throughput: one character per cycle while the four-entry token queue holds
// at most two tokens; characters that yield two tokens drain at one per cycle.
// The input register advances only when the queue has room for two tokens.
// end_of_text flushes the pending word or symbol and returns the lexer state to
// its initial value; ch is ignored then.
// Reset clears the input register, the queue and the lexer state. When the
// receiver stalls, the queue fills and chars.ready drops; no token is lost.
module pascal_subset_lexer (
  input  logic       clk,
  input  logic       rst,
  psl_char_if.sink   chars,
  psl_token_if.source tokens
);
  import psl_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_ch;
  logic       s1_eot;
  psl_state_t state;
  psl_state_t state_next;
  psl_step_t  step;
  logic       room;
  logic       advance;

  assign advance     = s1_valid && room;
  assign chars.ready = !s1_valid || room;

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s1_ch  <= chars.ch;
      s1_eot <= chars.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      state    <= RESET_STATE;
    end else begin
      if (chars.valid && chars.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        state <= state_next;
      end
    end
  end

  psl_lexstep u_step (
    .state      (state),
    .ch         (s1_ch),
    .eot        (s1_eot),
    .state_next (state_next),
    .step       (step)
  );

  psl_token_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (advance),
    .step   (step),
    .room   (room),
    .tokens (tokens)
  );

endmodule

// ===== rtl/psl_checker.sv =====
// Port-level checks of the Pascal subset lexer and their bind.
module psl_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [psl_pkg::TOK_W-1:0] token_class,
  input logic                       last
);
  import psl_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_class) && $stable(last))
    else $error("token changed while stalled");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_class <= TOK_IDENT)
    else $error("token class out of range");

  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("second token of a character missing");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not empty after reset");

endmodule

bind pascal_subset_lexer psl_checker u_psl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (chars.ready),
  .out_valid   (tokens.valid),
  .out_ready   (tokens.ready),
  .token_class (tokens.token_class),
  .last        (tokens.last)
);

// ===== bench/pascal_subset_lexer_test.sv =====
// Self-checking bench for the Pascal subset lexer: directed table, random text, token predictor.
module pascal_subset_lexer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import psl_pkg::*;

  typedef enum logic [TOK_W-1:0] {
    KW_PROGRAM   = 6'd0,
    KW_LABEL     = 6'd1,
    KW_TYPE      = 6'd2,
    KW_VAR       = 6'd3,
    KW_PROCEDURE = 6'd4,
    KW_FUNCTION  = 6'd5,
    KW_BEGIN     = 6'd6,
    KW_END       = 6'd7,
    KW_IF        = 6'd9,
    KW_THEN      = 6'd10,
    KW_ELSE      = 6'd11,
    KW_WHILE     = 6'd12,
    KW_DO        = 6'd13,
    KW_GOTO      = 6'd14,
    KW_DIV       = 6'd18,
    KW_AND       = 6'd25,
    KW_OR        = 6'd26,
    KW_NOT       = 6'd27
  } kw_tok_t;

  localparam int PREDICTED  = -1;
  localparam int TEXT_ITEMS = 1850;

  typedef struct {
    logic [7:0]       ch;
    logic             eot;
    int               n;
    logic [TOK_W-1:0] t0;
    logic [TOK_W-1:0] t1;
  } char_req_t;

  string kw_word [NUM_KW] = '{
    "program", "label", "type", "var", "procedure", "function", "begin", "end", "if",
    "then", "else", "while", "do", "goto", "div", "and", "or", "not"
  };
  kw_tok_t kw_class [NUM_KW] = '{
    KW_PROGRAM, KW_LABEL, KW_TYPE, KW_VAR, KW_PROCEDURE, KW_FUNCTION, KW_BEGIN, KW_END,
    KW_IF, KW_THEN, KW_ELSE, KW_WHILE, KW_DO, KW_GOTO, KW_DIV, KW_AND, KW_OR, KW_NOT
  };
  string punct_text [18] = '{
    ":=", "<=", "<>", ">=", ":", "<", ">", "+", "-", "*", "=", "(", ")", "[", "]", ",",
    ".", ";"
  };

  logic clk;
  logic rst;

  psl_char_if  chars_bus ();
  psl_token_if tokens_bus ();

  pascal_subset_lexer dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_bus),
    .tokens (tokens_bus)
  );

  // predictor state
  logic              lx_in_word;
  logic              lx_digit_first;
  logic [NUM_KW-1:0] lx_cand;
  logic [3:0]        lx_pos;
  psl_pend_t         lx_pend;

  psl_tok_t  step_toks [$];
  psl_tok_t  awaited_tokens [$];
  char_req_t char_reqs [$];
  int        errors = 0;
  logic      sink_calm = 1'b0;
  int        stall_left = 0;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0d) || c == 8'h00;
  endfunction

  function automatic logic [TOK_W-1:0] punct_class(input logic [7:0] c);
    case (c)
      "+":     return TOK_PLUS;
      "-":     return TOK_MINUS;
      "*":     return TOK_STAR;
      "=":     return TOK_EQ;
      "(":     return TOK_LPAREN;
      ")":     return TOK_RPAREN;
      "[":     return TOK_LBRACK;
      "]":     return TOK_RBRACK;
      ",":     return TOK_COMMA;
      ".":     return TOK_DOT;
      ";":     return TOK_SEMI;
      default: return TOK_IDENT;
    endcase
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("a" + r - 10);
    return 8'("A" + r - 36);
  endfunction

  task automatic clear_lexer();
    lx_in_word     = 1'b0;
    lx_digit_first = 1'b0;
    lx_cand        = '1;
    lx_pos         = 4'd0;
    lx_pend        = PEND_NONE;
  endtask

  task automatic emit(input logic [TOK_W-1:0] code);
    step_toks.push_back('{token_class: code, last: 1'b0});
  endtask

  task automatic close_word();
    logic [TOK_W-1:0] code;
    int k;
    if (lx_in_word) begin
      code = lx_digit_first ? TOK_NUMBER : TOK_IDENT;
      // scan downward so the lowest matching keyword wins
      for (k = NUM_KW - 1; k >= 0; k--) begin
        if (lx_cand[k] && kw_word[k].len() == lx_pos) code = kw_class[k];
      end
      emit(code);
      lx_in_word     = 1'b0;
      lx_digit_first = 1'b0;
      lx_cand        = '1;
      lx_pos         = 4'd0;
    end
  endtask

  task automatic close_symbol();
    case (lx_pend)
      PEND_COLON: emit(TOK_COLON);
      PEND_LT:    emit(TOK_LT);
      PEND_GT:    emit(TOK_GT);
      default: ;
    endcase
    lx_pend = PEND_NONE;
  endtask

  task automatic take_letter(input logic [7:0] c);
    int k;
    if (!lx_in_word) begin
      lx_in_word     = 1'b1;
      lx_digit_first = is_digit(c);
      lx_cand        = '1;
      lx_pos         = 4'd0;
    end
    for (k = 0; k < NUM_KW; k++) begin
      if (!(lx_pos < kw_word[k].len() && kw_word[k][lx_pos] == c)) lx_cand[k] = 1'b0;
    end
    if (lx_pos != 4'd15) lx_pos = lx_pos + 4'd1;
  endtask

  // Tokens caused by one character request, left in step_toks.
  task automatic lex_char(input logic [7:0] c, input logic eot);
    logic             paired;
    logic [TOK_W-1:0] pair;
    psl_tok_t         tail;
    step_toks.delete();
    paired = 1'b0;
    pair   = TOK_IDENT;
    if (eot) begin
      close_word();
      close_symbol();
      clear_lexer();
    end else begin
      if (lx_pend != PEND_NONE) begin
        if (lx_pend == PEND_COLON && c == "=") begin
          paired = 1'b1;
          pair   = TOK_ASSIGN;
        end else if (lx_pend == PEND_LT && c == "=") begin
          paired = 1'b1;
          pair   = TOK_LE;
        end else if (lx_pend == PEND_LT && c == ">") begin
          paired = 1'b1;
          pair   = TOK_NE;
        end else if (lx_pend == PEND_GT && c == "=") begin
          paired = 1'b1;
          pair   = TOK_GE;
        end
        if (paired) begin
          lx_pend = PEND_NONE;
          emit(pair);
        end else begin
          close_symbol();
        end
      end
      if (!paired) begin
        if (is_alnum(c)) begin
          take_letter(c);
        end else begin
          close_word();
          if (!is_space(c)) begin
            case (c)
              ":":     lx_pend = PEND_COLON;
              "<":     lx_pend = PEND_LT;
              ">":     lx_pend = PEND_GT;
              default: emit(punct_class(c));
            endcase
          end
        end
      end
    end
    if (step_toks.size() > 0) begin
      tail      = step_toks.pop_back();
      tail.last = 1'b1;
      step_toks.push_back(tail);
    end
  endtask

  task automatic add_row(input logic [7:0] c, input logic eot, input int n,
                         input logic [TOK_W-1:0] t0 = TOK_IDENT,
                         input logic [TOK_W-1:0] t1 = TOK_IDENT);
    char_reqs.push_back('{ch: c, eot: eot, n: n, t0: t0, t1: t1});
  endtask

  task automatic add_bytes(input logic [7:0] frag [$]);
    int i;
    for (i = 0; i < frag.size(); i++) add_row(frag[i], 1'b0, PREDICTED);
  endtask

  // Mostly well-formed program text, with mangled keywords and raw noise mixed in.
  task automatic add_random_text(input int target);
    logic [7:0] frag [$];
    string      s;
    int         r;
    int         len;
    int         i;
    while (char_reqs.size() < target) begin
      frag.delete();
      r = $urandom_range(0, 99);
      if (r < 28) begin
        s = kw_word[$urandom_range(0, NUM_KW - 1)];
        for (i = 0; i < s.len(); i++) frag.push_back(s[i]);
        case ($urandom_range(0, 9))
          0:       frag.push_back(rand_alnum());
          1:       if (frag.size() > 1) void'(frag.pop_back());
          2:       frag[0] = frag[0] - 8'd32;
          default: ;
        endcase
      end else if (r < 42) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 6);
        frag.push_back(8'("a" + $urandom_range(0, 25)));
        for (i = 0; i < len; i++) frag.push_back(rand_alnum());
      end else if (r < 50) begin
        len = $urandom_range(1, 6);
        for (i = 0; i < len; i++) frag.push_back(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 9) == 0) frag.push_back(rand_alnum());
      end else if (r < 76) begin
        s = punct_text[$urandom_range(0, 17)];
        for (i = 0; i < s.len(); i++) frag.push_back(s[i]);
      end else if (r < 84) begin
        frag.push_back(8'($urandom_range(0, 255)));
      end else if (r < 87) begin
        add_row(8'($urandom_range(0, 255)), 1'b1, PREDICTED);
      end
      add_bytes(frag);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: ;
        4:          add_row(8'(8'h09 + $urandom_range(0, 4)), 1'b0, PREDICTED);
        5:          add_row(8'h00, 1'b0, PREDICTED);
        default:    add_row(" ", 1'b0, PREDICTED);
      endcase
    end
    add_row(8'h00, 1'b1, PREDICTED);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // token sink: random stalls with calm stretches
  always @(posedge clk) begin
    if (rst) begin
      tokens_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      tokens_bus.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      tokens_bus.ready <= 1'b1;
      if (!sink_calm && $urandom_range(0, 99) < 25) stall_left <= idle_len();
      if ($urandom_range(0, 299) == 0) sink_calm <= !sink_calm;
    end
  end

  always @(posedge clk) begin
    psl_tok_t want;
    if (!rst && tokens_bus.valid && tokens_bus.ready) begin
      if (awaited_tokens.size() == 0) begin
        $error("token_class: expected none, actual %0d", tokens_bus.token_class);
        errors++;
      end else begin
        want = awaited_tokens.pop_front();
        if (tokens_bus.token_class !== want.token_class) begin
          $error("token_class: expected %0d, actual %0d", want.token_class,
                 tokens_bus.token_class);
          errors++;
        end
        if (tokens_bus.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, tokens_bus.last);
          errors++;
        end
      end
    end
  end

  initial begin
    char_req_t req;
    logic      src_calm;
    int        gap;
    int        i;
    src_calm              = 1'b0;
    rst                   = 1'b1;
    chars_bus.valid       = 1'b0;
    chars_bus.ch          = 8'h00;
    chars_bus.end_of_text = 1'b0;
    clear_lexer();

    add_row(8'h00, 1'b1, 0);
    add_row(":", 1'b0, 0);
    add_row("=", 1'b0, 1, TOK_ASSIGN);
    add_row("<", 1'b0, 0);
    add_row(">", 1'b0, 1, TOK_NE);
    add_row("<", 1'b0, 0);
    add_row("=", 1'b0, 1, TOK_LE);
    add_row(">", 1'b0, 0);
    add_row("=", 1'b0, 1, TOK_GE);
    add_row("d", 1'b0, 0);
    add_row("o", 1'b0, 0);
    add_row(";", 1'b0, 2, KW_DO, TOK_SEMI);
    add_row("9", 1'b0, 0);
    add_row("a", 1'b0, 0);
    add_row(8'hff, 1'b1, 1, TOK_NUMBER);
    add_row(8'hff, 1'b0, 1, TOK_IDENT);
    add_row(8'h00, 1'b0, 0);
    add_row(">", 1'b0, 0);
    add_row("z", 1'b0, 1, TOK_GT);
    add_row(8'h09, 1'b0, 1, TOK_IDENT);
    add_row(":", 1'b0, 0);
    add_row(8'h3d, 1'b1, 1, TOK_COLON);
    add_row("Z", 1'b0, 0);
    add_row("<", 1'b0, 1, TOK_IDENT);
    add_row("+", 1'b0, 2, TOK_LT, TOK_PLUS);
    add_row(8'h80, 1'b0, 1, TOK_IDENT);
    add_random_text(TEXT_ITEMS);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < char_reqs.size(); i++) begin
      req = char_reqs[i];
      if ($urandom_range(0, 149) == 0) src_calm = !src_calm;
      gap = (!src_calm && $urandom_range(0, 99) < 35) ? idle_len() : 0;
      if (gap > 0) begin
        chars_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      chars_bus.valid       <= 1'b1;
      chars_bus.ch          <= req.ch;
      chars_bus.end_of_text <= req.eot;
      do @(posedge clk); while (!chars_bus.ready);
      lex_char(req.ch, req.eot);
      if (req.n == PREDICTED) begin
        foreach (step_toks[j]) awaited_tokens.push_back(step_toks[j]);
      end else begin
        if (req.n >= 1) awaited_tokens.push_back('{token_class: req.t0, last: req.n == 1});
        if (req.n == 2) awaited_tokens.push_back('{token_class: req.t1, last: 1'b1});
      end
    end
    chars_bus.valid <= 1'b0;

    while (awaited_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== pascal_subset_lexer.f =====
rtl/psl_pkg.sv
rtl/psl_if.sv
rtl/psl_lexstep.sv
rtl/psl_token_fifo.sv
rtl/pascal_subset_lexer.sv
rtl/psl_checker.sv
bench/pascal_subset_lexer_test.sv
